### hdl/dpd_pkg.sv
// shared constants, types and the hex digit decoder for the debug packet deframer
package dpd_pkg;

   // default depth of the payload buffer
   localparam int unsigned MaxLenDefault = 256;

   // reset value and width of the max_len register
   localparam int unsigned MaxLenW     = 9;
   localparam logic [8:0]  MaxLenReset = 9'd256;

   // framing characters
   localparam logic [7:0] ChStart = 8'h24;  // '$'
   localparam logic [7:0] ChEnd   = 8'h23;  // '#'
   localparam logic [7:0] ChAck   = 8'h2B;  // '+'
   localparam logic [7:0] ChNak   = 8'h2D;  // '-'

   // status codes
   localparam logic [2:0] StBusy     = 3'd0;
   localparam logic [2:0] StAccepted = 3'd1;
   localparam logic [2:0] StBadSum   = 3'd2;
   localparam logic [2:0] StOverflow = 3'd3;
   localparam logic [2:0] StRestart  = 3'd4;

   // width of the packed result beat, padded to whole bytes
   localparam int unsigned RspW = 40;

   // one result item
   typedef struct packed {
      logic [8:0] packet_length;
      logic [2:0] status;
      logic [7:0] write_data;
      logic [7:0] write_index;
      logic       write_valid;
      logic [7:0] tx_byte;
      logic       tx_valid;
   } rsp_type;

   // decoded hex digit
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // ascii hex digit, either case
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

### hdl/debug_packet_deframer.sv
// top level of the debug packet deframer: '$' payload '#' checksum framing
// a req beat reaches its rsp beat through the input register and then the result register
// throughput: one byte per cycle while results are read; all the work is one pass through the framing logic
// an unread result holds its register while one more req beat waits in the input register
// reset: synchronous, active high; framer idle, count and sum zero, max_len 256
module debug_packet_deframer #(
   parameter int unsigned MAX_LEN = dpd_pkg::MaxLenDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // rx_byte
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // tx_valid, tx_byte, write_valid, write_index, write_data, status, packet_length, pad
   output logic [dpd_pkg::RspW-1:0] rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [8:0]               csr_wdata    // max_len
);

   logic             byte_valid;
   logic [7:0]       rx_byte;
   logic             byte_take;
   dpd_pkg::rsp_type rsp;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // input register
   dpd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .byte_valid (byte_valid),
      .rx_byte    (rx_byte),
      .byte_take  (byte_take)
   );

   // framer and result register
   dpd_frame_fsm #(
      .MAX_LEN (MAX_LEN)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_value  (csr_wdata),
      .byte_valid (byte_valid),
      .rx_byte    (rx_byte),
      .byte_take  (byte_take),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // pack the result beat, tx_valid lowest and the pad highest
   assign rsp_tdata = {2'b00, rsp.packet_length, rsp.status, rsp.write_data,
                       rsp.write_index, rsp.write_valid, rsp.tx_byte, rsp.tx_valid};

endmodule

### hdl/dpd_input_stage.sv
// input register: holds one received byte until the framing stage takes it
module dpd_input_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // rx_byte
   output logic       byte_valid,
   output logic [7:0] rx_byte,
   input  logic       byte_take
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // free when empty or when the held byte moves on this cycle
   assign req_tready = !valid_ff || byte_take;

   // next values
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_tdata;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign rx_byte    = byte_ff;

endmodule

### hdl/dpd_frame_fsm.sv
// framing state machine, checksum tracking and the result register
module dpd_frame_fsm #(
   parameter int unsigned MAX_LEN = dpd_pkg::MaxLenDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [8:0]           csr_value,
   input  logic                 byte_valid,
   input  logic [7:0]           rx_byte,
   output logic                 byte_take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dpd_pkg::rsp_type     rsp
);

   localparam int unsigned CntW = $clog2(MAX_LEN + 1);
   localparam int unsigned CmpW = (CntW > dpd_pkg::MaxLenW) ? CntW : dpd_pkg::MaxLenW;
   localparam logic [CmpW-1:0] LimitTop = CmpW'(MAX_LEN);

   // phase codes
   localparam logic [1:0] PhIdle = 2'd0;
   localparam logic [1:0] PhData = 2'd1;
   localparam logic [1:0] PhHi   = 2'd2;
   localparam logic [1:0] PhLo   = 2'd3;

   logic [8:0]       max_len_ff;
   logic [1:0]       phase_ff, phase_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [3:0]       high_ff, high_in;
   logic             high_ok_ff, high_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   dpd_pkg::rsp_type rsp_ff, rsp_in;

   logic [CmpW-1:0]  limit;
   logic [CmpW-1:0]  max_ext;
   logic [CmpW-1:0]  count_ext;
   logic [CmpW-1:0]  count_inc;
   logic [CmpW-1:0]  plen_ext;
   logic [7:0]       got_sum;
   dpd_pkg::hex_type digit;
   logic             advance;

   // a byte moves on when the result register is free
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign byte_take = byte_valid && advance;

   // limit in use: max_len clamped to 1..MAX_LEN
   always_comb begin
      max_ext = CmpW'(max_len_ff);
      if (max_len_ff == 9'd0) begin
         limit = CmpW'(1);
      end else if (max_ext > LimitTop) begin
         limit = LimitTop;
      end else begin
         limit = max_ext;
      end
   end

   assign count_ext = CmpW'(count_ff);
   assign count_inc = count_ext + CmpW'(1);
   assign digit     = dpd_pkg::hex_decode(rx_byte);

   // received checksum from the two digits
   always_comb begin
      if (!high_ok_ff) begin
         got_sum = 8'd0;
      end else if (!digit.ok) begin
         got_sum = {4'd0, high_ff};
      end else begin
         got_sum = {high_ff, digit.value};
      end
   end

   // one step of the framer
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      high_in    = high_ff;
      high_ok_in = high_ok_ff;
      rsp_in     = '0;
      plen_ext   = count_ext;
      case (phase_ff)
         PhIdle: begin
            if (rx_byte == dpd_pkg::ChStart) begin
               phase_in = PhData;
               count_in = '0;
               sum_in   = 8'd0;
               plen_ext = '0;
            end
         end
         PhData: begin
            if (rx_byte == dpd_pkg::ChStart) begin
               count_in      = '0;
               sum_in        = 8'd0;
               plen_ext      = '0;
               rsp_in.status = dpd_pkg::StRestart;
            end else if (rx_byte == dpd_pkg::ChEnd) begin
               phase_in = PhHi;
            end else begin
               sum_in             = sum_ff + rx_byte;
               rsp_in.write_valid = 1'b1;
               rsp_in.write_index = count_ext[7:0];
               rsp_in.write_data  = rx_byte;
               count_in           = CntW'(count_inc);
               plen_ext           = count_inc;
               if (count_inc >= limit) begin
                  rsp_in.tx_valid = 1'b1;
                  rsp_in.tx_byte  = dpd_pkg::ChNak;
                  rsp_in.status   = dpd_pkg::StOverflow;
                  phase_in        = PhIdle;
               end
            end
         end
         PhHi: begin
            high_in    = digit.ok ? digit.value : 4'd0;
            high_ok_in = digit.ok;
            phase_in   = PhLo;
         end
         PhLo: begin
            rsp_in.tx_valid = 1'b1;
            if (got_sum == sum_ff) begin
               rsp_in.tx_byte = dpd_pkg::ChAck;
               rsp_in.status  = dpd_pkg::StAccepted;
               phase_in       = PhIdle;
            end else begin
               rsp_in.tx_byte = dpd_pkg::ChNak;
               rsp_in.status  = dpd_pkg::StBadSum;
               phase_in       = PhData;
               count_in       = '0;
               sum_in         = 8'd0;
            end
         end
         default: begin
            phase_in = PhIdle;
         end
      endcase
      rsp_in.packet_length = plen_ext[8:0];
   end

   // result valid follows the byte hand-off
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = byte_valid;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= dpd_pkg::MaxLenReset;
         phase_ff     <= PhIdle;
         count_ff     <= '0;
         sum_ff       <= 8'd0;
         high_ff      <= 4'd0;
         high_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            max_len_ff <= csr_value;
         end
         if (byte_take) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            sum_ff     <= sum_in;
            high_ff    <= high_in;
            high_ok_ff <= high_ok_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (byte_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
